/* src/trie_string_counter_assert.svh */
// ----------------------------------------------------------------------
// trie_string_counter_assert: assertion macros used by the trie string counter RTL.
// Each macro checks one implication on the rising clock edge, outside reset.
// ----------------------------------------------------------------------
`ifndef TRIE_STRING_COUNTER_ASSERT_SVH
`define TRIE_STRING_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/tsc_pkg.sv */
// ----------------------------------------------------------------------
// tsc_pkg: shared constants for the trie string counter.
// Sizes of the node pool, the alphabet and the counts, and derived widths.
// ----------------------------------------------------------------------
package tsc_pkg;

    localparam int MAX_NODES  = 65536;
    localparam int ALPHABET   = 26;
    localparam int COUNT_BITS = 16;

    // Fixed widths of the request and result fields.
    localparam int LETTER_W = 5;
    localparam int OCC_W    = 16;

    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int SLOT_DEPTH  = MAX_NODES * ALPHABET;
    localparam int SLOT_W      = $clog2(SLOT_DEPTH);
    // A node word holds the slot of the parent link that owns it, then its count.
    localparam int NODE_WORD_W = SLOT_W + COUNT_BITS;

endpackage

/* src/tsc_ram.sv */
// ----------------------------------------------------------------------
// tsc_ram: generic simple dual-port RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------
module tsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/trie_string_counter.sv */
// ----------------------------------------------------------------------
// trie_string_counter: prefix trie that counts inserted lowercase strings.
// Requests are taken one at a time. A letter reads its child link; when the link points
// into the pool, the node word is read next so that the parent tag can confirm the link.
// A last request then passes through a count state, held while the result register is
// stalled; a letterless last request goes straight to it. The result is registered there.
// Synchronous reset clears the walk and the pool pointer at once; no memory clearing pass.
// ----------------------------------------------------------------------
module trie_string_counter
    import tsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_req_type,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic                i_no_letter,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [OCC_W-1:0]    o_occurrences,
    output logic                o_pool_full
);

`include "trie_string_counter_assert.svh"

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHILD = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_COUNT = 4'b1000
    } t_state;

    localparam logic [NODE_W-1:0]     NODE_LAST = NODE_W'(MAX_NODES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    t_state r_state, n_state;

    logic [NODE_W-1:0] r_walk, n_walk;
    logic [NODE_W-1:0] r_free, n_free;
    logic [NODE_W-1:0] r_cand, n_cand;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_missed, n_missed;
    logic              r_ovf, n_ovf;
    logic              r_query, n_query;
    logic              r_last, n_last;
    logic              r_fresh, n_fresh;
    logic              r_root_ok, n_root_ok;
    logic              r_out_valid, n_out_valid;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic              r_full, n_full;

    logic                   child_we, child_re;
    logic [SLOT_W-1:0]      child_waddr, child_raddr;
    logic [NODE_W-1:0]      child_wdata, child_rdata;
    logic                   node_we, node_re;
    logic [NODE_W-1:0]      node_waddr, node_raddr;
    logic [NODE_WORD_W-1:0] node_wdata, node_rdata;

    logic                  in_accept;
    logic                  has_letter;
    logic [SLOT_W-1:0]     in_slot;
    logic                  link_ok;
    logic                  tag_ok;
    logic                  can_alloc;
    logic [NODE_W-1:0]     new_node;
    logic [SLOT_W-1:0]     stored_parent;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic [COUNT_BITS-1:0] res_count;
    logic [31:0]           res_ext;
    logic                  broken;
    logic                  out_free;
    logic                  miss;
    logic                  step_done;

    // Child links: one entry per node and letter, zero or stale until written.
    tsc_ram #(
        .WIDTH (NODE_W),
        .DEPTH (SLOT_DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_re    (child_re),
        .i_raddr (child_raddr),
        .o_rdata (child_rdata)
    );

    // Node words: owning parent slot and end count, written when a node is allocated or counted.
    tsc_ram #(
        .WIDTH (NODE_WORD_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    assign o_in_stall    = (r_state != ST_IDLE);
    assign in_accept     = i_in_valid && (r_state == ST_IDLE);
    assign has_letter    = !i_no_letter && (32'(i_letter) < 32'(ALPHABET));
    assign in_slot       = SLOT_W'(SLOT_W'(r_walk) * SLOT_W'(ALPHABET)) + SLOT_W'(i_letter);

    // A link is only trusted if it points into the allocated pool and the node
    // it names records this very slot as its parent; stale memory fails the check.
    assign link_ok       = (child_rdata != '0) && (child_rdata <= r_free);
    assign stored_parent = node_rdata[NODE_WORD_W-1 -: SLOT_W];
    assign tag_ok        = (stored_parent == r_slot);
    assign can_alloc     = (r_free != NODE_LAST);
    assign new_node      = r_free + NODE_W'(1);

    // A node allocated in the last step still reads stale data, and the root
    // count is never written before the first insert of the empty string.
    assign cur_count = (r_fresh || ((r_walk == '0) && !r_root_ok)) ?
                       '0 : node_rdata[COUNT_BITS-1:0];
    assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);
    assign broken    = r_missed || r_ovf;
    assign res_count = broken ? '0 : (r_query ? cur_count : inc_count);
    assign res_ext   = 32'(res_count);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_free      = r_free;
        n_cand      = r_cand;
        n_slot      = r_slot;
        n_missed    = r_missed;
        n_ovf       = r_ovf;
        n_query     = r_query;
        n_last      = r_last;
        n_fresh     = r_fresh;
        n_root_ok   = r_root_ok;
        n_out_valid = r_out_valid && i_out_stall;
        n_occ       = r_occ;
        n_full      = r_full;
        child_we    = 1'b0;
        child_waddr = r_slot;
        child_wdata = new_node;
        child_re    = 1'b0;
        child_raddr = in_slot;
        node_we     = 1'b0;
        node_waddr  = new_node;
        node_wdata  = {r_slot, {COUNT_BITS{1'b0}}};
        node_re     = 1'b0;
        node_raddr  = r_walk;
        miss        = 1'b0;
        step_done   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_query = i_req_type;
                    n_last  = i_last;
                    if (has_letter && !r_missed && !r_ovf) begin
                        child_re = 1'b1;
                        n_slot   = in_slot;
                        n_state  = ST_CHILD;
                    end else if (i_last) begin
                        node_re = 1'b1;
                        n_state = ST_COUNT;
                    end
                end
            end
            ST_CHILD: begin
                if (link_ok) begin
                    node_re    = 1'b1;
                    node_raddr = child_rdata;
                    n_cand     = child_rdata;
                    n_state    = ST_CHECK;
                end else begin
                    miss = 1'b1;
                end
            end
            ST_CHECK: begin
                if (tag_ok) begin
                    n_walk    = r_cand;
                    n_fresh   = 1'b0;
                    step_done = 1'b1;
                end else begin
                    miss = 1'b1;
                end
            end
            ST_COUNT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_occ       = res_ext[OCC_W-1:0];
                    n_full      = !r_query && r_ovf;
                    if (!r_query && !broken) begin
                        node_we    = 1'b1;
                        node_waddr = r_walk;
                        node_wdata = {(r_fresh ? r_slot : stored_parent), inc_count};
                        if (r_walk == '0) begin
                            n_root_ok = 1'b1;
                        end
                    end
                    n_walk   = '0;
                    n_missed = 1'b0;
                    n_ovf    = 1'b0;
                    n_fresh  = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (miss) begin
            step_done = 1'b1;
            if (r_query) begin
                n_missed = 1'b1;
            end else if (can_alloc) begin
                child_we = 1'b1;
                node_we  = 1'b1;
                n_free   = new_node;
                n_walk   = new_node;
                n_fresh  = 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (step_done) begin
            if (r_last) begin
                node_re    = 1'b1;
                node_raddr = n_walk;
                n_state    = ST_COUNT;
            end else begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_walk      <= '0;
            r_free      <= '0;
            r_missed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_fresh     <= 1'b0;
            r_root_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_free      <= n_free;
            r_missed    <= n_missed;
            r_ovf       <= n_ovf;
            r_fresh     <= n_fresh;
            r_root_ok   <= n_root_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_slot  <= n_slot;
        r_query <= n_query;
        r_last  <= n_last;
        r_occ   <= n_occ;
        r_full  <= n_full;
    end

    assign o_out_valid   = r_out_valid;
    assign o_occurrences = r_occ;
    assign o_pool_full   = r_full;

    // The walk never points beyond the nodes handed out so far.
    `TSC_ASSERT_IMP(a_walk_in_pool, i_clk, i_rst_n, 1'b1, r_walk <= r_free)
    // A broken walk is broken for exactly one reason.
    `TSC_ASSERT_IMP(a_single_break, i_clk, i_rst_n, 1'b1, !(r_missed && r_ovf))
    // Each new link names the node that the pool pointer moves to.
    `TSC_ASSERT_NEXT(a_alloc_link, i_clk, i_rst_n, child_we, r_free == $past(child_wdata))

endmodule
